>>> rtl/xcr_pkg.sv
package xcr_pkg;

  localparam int QueueDepthDef = 4;

  localparam logic [7:0] PosFirstData = 8'd3;
  localparam logic [7:0] PosChecksum  = 8'd131;
  localparam logic [7:0] PosNumber    = 8'd1;
  localparam logic [7:0] PosInverse   = 8'd2;
  localparam logic [7:0] PosStart     = 8'd0;
  localparam logic [7:0] BlockStep    = 8'd128;
  localparam logic [7:0] ComplementOk = 8'hFF;
  localparam logic [7:0] SeqFirst     = 8'd1;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  localparam logic [15:0] TimeoutReset  = 16'd3000;
  localparam logic [7:0]  InnerLimReset = 8'd10;
  localparam logic [7:0]  OuterLimReset = 8'd3;
  localparam logic [31:0] BaseReset     = 32'd0;

  localparam int TdataW = 64;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [3:0] {
    ST_BYTE     = 4'd0,
    ST_ACCEPTED = 4'd1,
    ST_EOT      = 4'd2,
    ST_TIMEOUT  = 4'd3,
    ST_GAVE_UP  = 4'd4,
    ST_BAD_SOH  = 4'd5,
    ST_BAD_CPL  = 4'd6,
    ST_BAD_SUM  = 4'd7,
    ST_SEQ_ERR  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_INNER   = 2'd1,
    REG_OUTER   = 2'd2,
    REG_BASE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        stage_valid;
    logic [6:0]  stage_offset;
    logic [7:0]  stage_byte;
    logic        commit;
    logic [31:0] commit_address;
    status_t     status;
    logic        last;
  } result_t;

endpackage

>>> rtl/xcr_front.sv
module xcr_front #(
  parameter int QueueDepth = xcr_pkg::QueueDepthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_tuser,
  input  logic [7:0]       in_tdata,
  output xcr_pkg::q_head_t head,
  input  logic             pop
);

  localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);

  xcr_pkg::cmd_t  mem_r [QueueDepth];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push;
  logic           do_pop;
  xcr_pkg::cmd_t  cmd_in;

  assign cmd_in.kind = in_tuser ? xcr_pkg::CMD_TICK : xcr_pkg::CMD_BYTE;
  assign cmd_in.data = in_tdata;

  assign in_tready = (count_r != CW'(QueueDepth));
  assign push      = in_tvalid && in_tready;
  assign do_pop    = pop && head.valid;

  assign head.valid = (count_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QueueDepth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

>>> rtl/xcr_back.sv
module xcr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  xcr_pkg::q_head_t           head,
  output logic                       pop,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [xcr_pkg::TdataW-1:0] out_tdata,
  output logic [3:0]                 out_tuser,
  output logic                       out_tlast
);

  logic [15:0] timeout_r, timeout_nxt;
  logic [7:0]  inner_lim_r, inner_lim_nxt;
  logic [7:0]  outer_lim_r, outer_lim_nxt;
  logic [31:0] base_r, base_nxt;

  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  start_r, start_nxt;
  logic [7:0]  blk_r, blk_nxt;
  logic [7:0]  inv_r, inv_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [31:0] waddr_r, waddr_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  inner_r, inner_nxt;
  logic [7:0]  outer_left_r, outer_left_nxt;
  logic        fin_r, fin_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              pend_r, pend_nxt;
  xcr_pkg::result_t  out_r, out_nxt;

  logic              room;
  logic              res_v;
  logic              two;
  xcr_pkg::result_t  res;
  xcr_pkg::result_t  gave_up;
  logic [15:0]       tick_inc;
  logic [7:0]        inner_inc;
  logic [7:0]        b;
  logic              new_pkt;

  assign cfg_ready = 1'b1;
  assign room      = !out_valid_r || out_tready;
  assign pop       = head.valid && room && !pend_r;
  assign tick_inc  = tick_r + 16'd1;
  assign inner_inc = inner_r + 8'd1;
  assign b         = head.cmd.data;

  always_comb begin
    gave_up          = '0;
    gave_up.tx_valid = 1'b1;
    gave_up.tx_byte  = xcr_pkg::CH_NAK;
    gave_up.status   = xcr_pkg::ST_GAVE_UP;
    gave_up.last     = 1'b1;
  end

  always_comb begin
    timeout_nxt    = timeout_r;
    inner_lim_nxt  = inner_lim_r;
    outer_lim_nxt  = outer_lim_r;
    base_nxt       = base_r;
    pos_nxt        = pos_r;
    start_nxt      = start_r;
    blk_nxt        = blk_r;
    inv_nxt        = inv_r;
    sum_nxt        = sum_r;
    seq_nxt        = seq_r;
    waddr_nxt      = waddr_r;
    tick_nxt       = tick_r;
    inner_nxt      = inner_r;
    outer_left_nxt = outer_left_r;
    fin_nxt        = fin_r;
    res            = '0;
    res.status     = xcr_pkg::ST_BYTE;
    res_v          = 1'b0;
    two            = 1'b0;
    new_pkt        = 1'b0;

    if (pop && !fin_r) begin
      if (head.cmd.kind == xcr_pkg::CMD_TICK) begin
        tick_nxt = tick_inc;
        if (tick_inc >= timeout_r) begin
          tick_nxt     = '0;
          inner_nxt    = inner_inc;
          res_v        = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_byte  = xcr_pkg::CH_NAK;
          res.status   = xcr_pkg::ST_TIMEOUT;
          if (inner_inc >= inner_lim_r) begin
            two = 1'b1;
            if (outer_left_r <= 8'd1) begin
              seq_nxt        = xcr_pkg::SeqFirst;
              outer_left_nxt = outer_lim_r;
            end else begin
              outer_left_nxt = outer_left_r - 8'd1;
            end
            new_pkt = 1'b1;
          end else begin
            res.last = 1'b1;
          end
        end
      end else begin
        inner_nxt = '0;
        res_v     = 1'b1;
        res.last  = 1'b1;
        if (pos_r == xcr_pkg::PosStart) begin
          start_nxt = b;
        end
        if (pos_r == xcr_pkg::PosNumber) begin
          blk_nxt = b;
        end
        if (pos_r == xcr_pkg::PosInverse) begin
          inv_nxt = b;
        end
        if (pos_r == xcr_pkg::PosStart && b == xcr_pkg::CH_EOT) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = xcr_pkg::CH_ACK;
          res.status   = xcr_pkg::ST_EOT;
          fin_nxt      = 1'b1;
        end else if (pos_r >= xcr_pkg::PosFirstData && pos_r < xcr_pkg::PosChecksum) begin
          sum_nxt          = sum_r + b;
          res.stage_valid  = 1'b1;
          res.stage_offset = 7'(pos_r - xcr_pkg::PosFirstData);
          res.stage_byte   = b;
          pos_nxt          = pos_r + 8'd1;
        end else if (pos_r < xcr_pkg::PosChecksum) begin
          pos_nxt = pos_r + 8'd1;
        end else begin
          res.tx_valid   = 1'b1;
          res.tx_byte    = xcr_pkg::CH_NAK;
          outer_left_nxt = outer_lim_r;
          new_pkt        = 1'b1;
          if (start_r != xcr_pkg::CH_SOH) begin
            res.status = xcr_pkg::ST_BAD_SOH;
          end else if ((blk_r ^ inv_r) != xcr_pkg::ComplementOk) begin
            res.status = xcr_pkg::ST_BAD_CPL;
          end else if (blk_r != seq_r) begin
            res.tx_byte = xcr_pkg::CH_CAN;
            res.status  = xcr_pkg::ST_SEQ_ERR;
            seq_nxt     = xcr_pkg::SeqFirst;
          end else if (sum_r != b) begin
            res.status = xcr_pkg::ST_BAD_SUM;
          end else begin
            res.tx_byte        = xcr_pkg::CH_ACK;
            res.status         = xcr_pkg::ST_ACCEPTED;
            res.commit         = 1'b1;
            res.commit_address = waddr_r;
            waddr_nxt          = waddr_r + 32'(xcr_pkg::BlockStep);
            seq_nxt            = seq_r + 8'd1;
          end
        end
      end
      if (new_pkt) begin
        pos_nxt   = '0;
        sum_nxt   = '0;
        tick_nxt  = '0;
        inner_nxt = '0;
      end
    end

    if (cfg_valid && cfg_ready) begin
      unique case (xcr_pkg::reg_idx_t'(cfg_index))
        xcr_pkg::REG_TIMEOUT: timeout_nxt = cfg_data[15:0];
        xcr_pkg::REG_INNER:   inner_lim_nxt = cfg_data[7:0];
        xcr_pkg::REG_OUTER: begin
          outer_lim_nxt  = cfg_data[7:0];
          outer_left_nxt = cfg_data[7:0];
        end
        xcr_pkg::REG_BASE: begin
          base_nxt  = cfg_data;
          waddr_nxt = cfg_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    if (room) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = gave_up;
        pend_nxt      = 1'b0;
      end else if (res_v) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
        pend_nxt      = two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= xcr_pkg::TimeoutReset;
      inner_lim_r  <= xcr_pkg::InnerLimReset;
      outer_lim_r  <= xcr_pkg::OuterLimReset;
      base_r       <= xcr_pkg::BaseReset;
      pos_r        <= '0;
      start_r      <= '0;
      blk_r        <= '0;
      inv_r        <= '0;
      sum_r        <= '0;
      seq_r        <= xcr_pkg::SeqFirst;
      waddr_r      <= xcr_pkg::BaseReset;
      tick_r       <= '0;
      inner_r      <= '0;
      outer_left_r <= xcr_pkg::OuterLimReset;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      timeout_r    <= timeout_nxt;
      inner_lim_r  <= inner_lim_nxt;
      outer_lim_r  <= outer_lim_nxt;
      base_r       <= base_nxt;
      pos_r        <= pos_nxt;
      start_r      <= start_nxt;
      blk_r        <= blk_nxt;
      inv_r        <= inv_nxt;
      sum_r        <= sum_nxt;
      seq_r        <= seq_nxt;
      waddr_r      <= waddr_nxt;
      tick_r       <= tick_nxt;
      inner_r      <= inner_nxt;
      outer_left_r <= outer_left_nxt;
      fin_r        <= fin_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.commit_address, out_r.commit, out_r.stage_byte,
                       out_r.stage_offset, out_r.stage_valid, out_r.tx_byte, out_r.tx_valid};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

  a_pend_has_first: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r && !out_r.last)
    else $error("second result pending without its first");

  a_fin_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("transfer end flag cleared");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= xcr_pkg::PosChecksum)
    else $error("byte position beyond packet");

  a_commit_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.commit |-> out_r.status == xcr_pkg::ST_ACCEPTED
      && out_r.tx_byte == xcr_pkg::CH_ACK)
    else $error("commit without acceptance");

endmodule

>>> rtl/xmodem_checksum_receiver_core.sv
// XMODEM receiver with an additive checksum. Each input item is a received byte (tuser low)
// or a millisecond tick (tuser high); the block frames 132-byte packets, offers data bytes
// for staging, answers with ACK, NAK or CAN and commits good blocks at an advancing address.
// It takes one item per clock cycle unless the output stalls or a second result is pending;
// a result passes through the input queue and output register. A tick that gives up a packet
// yields two results; a short queue in front absorbs that and any stall on the result side.
// Configuration writes are taken at any time but are meant for an idle block.
module xmodem_checksum_receiver_core #(
  parameter int QueueDepth = xcr_pkg::QueueDepthDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // rx_byte
  input  logic                       in_tuser,   // func
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // tx_valid, tx_byte, stage_valid, stage_offset, stage_byte, commit, commit_address
  output logic [xcr_pkg::TdataW-1:0] out_tdata,
  output logic [3:0]                 out_tuser,  // status
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);

  xcr_pkg::q_head_t head;
  logic             pop;

  xcr_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  xcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
